// ===== rtl/level_alarm_with_hysteresis_deadband_assert.svh =====
// Assertion macros shared by the alarm block's modules.
`ifndef LEVEL_ALARM_WITH_HYSTERESIS_DEADBAND_ASSERT_SVH
`define LEVEL_ALARM_WITH_HYSTERESIS_DEADBAND_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define LAHD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lahd: implication check failed");

// Next-cycle implication.
`define LAHD_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lahd: next-cycle check failed");

`else

`define LAHD_ASSERT_IMP(name, clk, rst, ante, cons)
`define LAHD_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/lahd_pkg.sv =====
package lahd_pkg;

   localparam int SAMPLE_W        = 32;
   localparam int CSR_W           = 32;
   localparam int CSR_ADDR_W      = 3;
   localparam int BAND_W          = 32;
   localparam int SEV_MAP_W       = 10;
   localparam int RSP_DATA_W      = 8;
   localparam int DEF_VALUE_WIDTH = 32;

   // Register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_HIHI      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HIGH      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOW       = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOLO      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_HYST      = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEV_MAP   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_VAL_BAND  = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_ARCH_BAND = 3'd7;

   // Two-bit slots of the severity map
   localparam int SLOT_HIHI = 0;
   localparam int SLOT_LOLO = 1;
   localparam int SLOT_HIGH = 2;
   localparam int SLOT_LOW  = 3;
   localparam int SLOT_FAIL = 4;

   typedef enum logic [2:0] {
      STAT_NONE  = 3'd0,
      STAT_SOFT  = 3'd1,
      STAT_UNDEF = 3'd2,
      STAT_HIHI  = 3'd3,
      STAT_LOLO  = 3'd4,
      STAT_HIGH  = 3'd5,
      STAT_LOW   = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      SEV_NONE    = 2'd0,
      SEV_MINOR   = 2'd1,
      SEV_MAJOR   = 2'd2,
      SEV_INVALID = 2'd3
   } severity_type;

   typedef struct packed {
      status_type   status;
      severity_type severity;
      logic         changed;
   } alarm_type;

endpackage

// ===== rtl/lahd_deadband.sv =====
module lahd_deadband #(
   parameter int VALUE_WIDTH = lahd_pkg::DEF_VALUE_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        upd,
   input  logic [VALUE_WIDTH-1:0]      val,
   input  logic [lahd_pkg::BAND_W-1:0] band,
   output logic                        evt
);

   localparam int CMP_W = (VALUE_WIDTH > lahd_pkg::BAND_W) ? VALUE_WIDTH : lahd_pkg::BAND_W;

   logic [VALUE_WIDTH-1:0] last_ff;
   logic [VALUE_WIDTH-1:0] last_in;
   logic [VALUE_WIDTH-1:0] diff;

   always_comb begin
      diff    = (last_ff >= val) ? (last_ff - val) : (val - last_ff);
      // negative band posts on every beat
      evt     = band[lahd_pkg::BAND_W-1] ||
                (CMP_W'(diff) > CMP_W'(band[lahd_pkg::BAND_W-2:0]));
      last_in = (upd && evt) ? val : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else begin
         last_ff <= last_in;
      end
   end

`include "level_alarm_with_hysteresis_deadband_assert.svh"

   `LAHD_ASSERT_IMP(a_neg_band_posts, clock, reset, upd && band[lahd_pkg::BAND_W-1], evt)
   `LAHD_ASSERT_NXT(a_hold_without_post, clock, reset, !(upd && evt), $stable(last_ff))

endmodule

// ===== rtl/lahd_alarm.sv =====
module lahd_alarm #(
   parameter int VALUE_WIDTH = lahd_pkg::DEF_VALUE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           upd,
   input  logic [VALUE_WIDTH-1:0]         val,
   input  logic                           failed,
   input  logic [VALUE_WIDTH-1:0]         hihi_lim,
   input  logic [VALUE_WIDTH-1:0]         high_lim,
   input  logic [VALUE_WIDTH-1:0]         low_lim,
   input  logic [VALUE_WIDTH-1:0]         lolo_lim,
   input  logic [VALUE_WIDTH-1:0]         hyst,
   input  logic [lahd_pkg::SEV_MAP_W-1:0] sev_map,
   output lahd_pkg::alarm_type            alarm
);

   logic [VALUE_WIDTH-1:0]  latched_ff;
   logic [VALUE_WIDTH-1:0]  latched_in;
   logic                    undef_ff;
   logic                    undef_in;
   lahd_pkg::status_type    prev_stat_ff;
   lahd_pkg::severity_type  prev_sev_ff;

   logic [1:0]              sev_hihi, sev_lolo, sev_high, sev_low, sev_fail;
   logic                    hihi_fire, lolo_fire, high_fire, low_fire;
   lahd_pkg::status_type    stat_c;
   logic [1:0]              sev_c;

   function automatic logic high_hit(input logic [VALUE_WIDTH-1:0] v,
                                     input logic [VALUE_WIDTH-1:0] lim,
                                     input logic [VALUE_WIDTH-1:0] lat,
                                     input logic [VALUE_WIDTH-1:0] hy);
      logic [VALUE_WIDTH-1:0] bound;
      bound = lim - hy;
      return (v >= lim) || (lat == lim && lim > hy && v >= bound);
   endfunction

   function automatic logic low_hit(input logic [VALUE_WIDTH-1:0] v,
                                    input logic [VALUE_WIDTH-1:0] lim,
                                    input logic [VALUE_WIDTH-1:0] lat,
                                    input logic [VALUE_WIDTH-1:0] hy);
      logic [VALUE_WIDTH-1:0] bound;
      bound = lim + hy;
      return (v <= lim) || (lat == lim && v <= bound);
   endfunction

   always_comb begin
      sev_hihi  = sev_map[2*lahd_pkg::SLOT_HIHI +: 2];
      sev_lolo  = sev_map[2*lahd_pkg::SLOT_LOLO +: 2];
      sev_high  = sev_map[2*lahd_pkg::SLOT_HIGH +: 2];
      sev_low   = sev_map[2*lahd_pkg::SLOT_LOW +: 2];
      sev_fail  = sev_map[2*lahd_pkg::SLOT_FAIL +: 2];

      hihi_fire = (sev_hihi != 2'd0) && high_hit(val, hihi_lim, latched_ff, hyst);
      lolo_fire = (sev_lolo != 2'd0) && low_hit(val, lolo_lim, latched_ff, hyst);
      high_fire = (sev_high != 2'd0) && high_hit(val, high_lim, latched_ff, hyst);
      low_fire  = (sev_low != 2'd0) && low_hit(val, low_lim, latched_ff, hyst);

      stat_c     = lahd_pkg::STAT_NONE;
      sev_c      = 2'd0;
      latched_in = latched_ff;

      if (failed && sev_fail != 2'd0) begin
         stat_c = lahd_pkg::STAT_SOFT;
         sev_c  = sev_fail;
      end
      undef_in = undef_ff && failed;

      if (undef_in) begin
         if (sev_c != 2'(lahd_pkg::SEV_INVALID)) begin
            stat_c = lahd_pkg::STAT_UNDEF;
            sev_c  = 2'(lahd_pkg::SEV_INVALID);
         end
      end else if (hihi_fire) begin
         if (sev_hihi > sev_c) begin
            stat_c     = lahd_pkg::STAT_HIHI;
            sev_c      = sev_hihi;
            latched_in = hihi_lim;
         end
      end else if (lolo_fire) begin
         if (sev_lolo > sev_c) begin
            stat_c     = lahd_pkg::STAT_LOLO;
            sev_c      = sev_lolo;
            latched_in = lolo_lim;
         end
      end else if (high_fire) begin
         if (sev_high > sev_c) begin
            stat_c     = lahd_pkg::STAT_HIGH;
            sev_c      = sev_high;
            latched_in = high_lim;
         end
      end else if (low_fire) begin
         if (sev_low > sev_c) begin
            stat_c     = lahd_pkg::STAT_LOW;
            sev_c      = sev_low;
            latched_in = low_lim;
         end
      end else begin
         latched_in = val;
      end

      alarm.status   = stat_c;
      alarm.severity = lahd_pkg::severity_type'(sev_c);
      alarm.changed  = (stat_c != prev_stat_ff) || (sev_c != 2'(prev_sev_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff   <= '0;
         undef_ff     <= 1'b1;
         prev_stat_ff <= lahd_pkg::STAT_NONE;
         prev_sev_ff  <= lahd_pkg::SEV_NONE;
      end else if (upd) begin
         latched_ff   <= latched_in;
         undef_ff     <= undef_in;
         prev_stat_ff <= alarm.status;
         prev_sev_ff  <= alarm.severity;
      end
   end

`include "level_alarm_with_hysteresis_deadband_assert.svh"

   `LAHD_ASSERT_NXT(a_defined_stays, clock, reset, !undef_ff, !undef_ff)

endmodule

// ===== rtl/level_alarm_with_hysteresis_deadband.sv =====
// Level alarm with hysteresis and monitor deadbands. Each request beat carries one
// unsigned sample and a flag that the step producing it failed; each beat yields exactly
// one response beat with the alarm status and severity, a flag that either changed since
// the previous beat, and value and archive events from two deadband trackers. A failure
// with a nonzero failure severity raises a soft alarm at that severity; until the first
// good sample the result is undefined/invalid. Limits are checked hihi, lolo, high, low,
// each enabled by a nonzero severity and held by hysteresis. Throughput is one beat per
// clock while the response side takes its beats; a beat sits in the input register after
// its accepting edge and its result is loaded into the result register once that register
// is free, then shows on the response. Alarm and deadband state update with that load.
// Write the csr registers only while no beat is in flight.
module level_alarm_with_hysteresis_deadband #(
   parameter int VALUE_WIDTH = lahd_pkg::DEF_VALUE_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lahd_pkg::SAMPLE_W-1:0]        req_tdata,  // [31:0] sample
   input  logic                                 req_tuser,  // [0] step_failed
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [2:0] alarm_status, [4:3] alarm_severity, [5] alarm_changed,
   // [6] value_event, [7] archive_event
   output logic [lahd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration
   input  logic                                 csr_we,
   input  logic [lahd_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [lahd_pkg::CSR_W-1:0]           csr_wdata
);

   // configuration registers
   logic [VALUE_WIDTH-1:0]          hihi_ff, high_ff, low_ff, lolo_ff, hyst_ff;
   logic [lahd_pkg::SEV_MAP_W-1:0]  sev_map_ff;
   logic [lahd_pkg::BAND_W-1:0]     val_band_ff, arch_band_ff;

   // input register
   logic                            s1_valid_ff, s1_valid_in;
   logic [VALUE_WIDTH-1:0]          s1_sample_ff;
   logic                            s1_failed_ff;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lahd_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                            req_fire, out_free, advance;
   lahd_pkg::alarm_type             alarm;
   logic                            val_evt, arch_evt;

   // views of the held result for the checks below
   logic [2:0]                      rsp_stat;
   logic [1:0]                      rsp_sev;
   logic                            chk_undef_sev, chk_none_sev, s1_stall;

   // The result register frees up when empty or when its beat leaves this cycle;
   // the input register then hands over its beat and can take a new one.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = {arch_evt, val_evt, alarm.changed, alarm.severity, alarm.status};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hihi_ff      <= '0;
         high_ff      <= '0;
         low_ff       <= '0;
         lolo_ff      <= '0;
         hyst_ff      <= '0;
         sev_map_ff   <= '0;
         val_band_ff  <= '0;
         arch_band_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            lahd_pkg::CSR_HIHI:      hihi_ff      <= VALUE_WIDTH'(csr_wdata);
            lahd_pkg::CSR_HIGH:      high_ff      <= VALUE_WIDTH'(csr_wdata);
            lahd_pkg::CSR_LOW:       low_ff       <= VALUE_WIDTH'(csr_wdata);
            lahd_pkg::CSR_LOLO:      lolo_ff      <= VALUE_WIDTH'(csr_wdata);
            lahd_pkg::CSR_HYST:      hyst_ff      <= VALUE_WIDTH'(csr_wdata);
            lahd_pkg::CSR_SEV_MAP:   sev_map_ff   <= csr_wdata[lahd_pkg::SEV_MAP_W-1:0];
            lahd_pkg::CSR_VAL_BAND:  val_band_ff  <= csr_wdata[lahd_pkg::BAND_W-1:0];
            lahd_pkg::CSR_ARCH_BAND: arch_band_ff <= csr_wdata[lahd_pkg::BAND_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: capture on accept, advance into the result register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sample_ff <= VALUE_WIDTH'(req_tdata[lahd_pkg::SAMPLE_W-1:0]);
         s1_failed_ff <= req_tuser;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   lahd_alarm #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_alarm (
      .clock    (clock),
      .reset    (reset),
      .upd      (advance),
      .val      (s1_sample_ff),
      .failed   (s1_failed_ff),
      .hihi_lim (hihi_ff),
      .high_lim (high_ff),
      .low_lim  (low_ff),
      .lolo_lim (lolo_ff),
      .hyst     (hyst_ff),
      .sev_map  (sev_map_ff),
      .alarm    (alarm)
   );

   lahd_deadband #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_val_band (
      .clock (clock),
      .reset (reset),
      .upd   (advance),
      .val   (s1_sample_ff),
      .band  (val_band_ff),
      .evt   (val_evt)
   );

   lahd_deadband #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_arch_band (
      .clock (clock),
      .reset (reset),
      .upd   (advance),
      .val   (s1_sample_ff),
      .band  (arch_band_ff),
      .evt   (arch_evt)
   );

   assign rsp_stat      = rsp_data_ff[2:0];
   assign rsp_sev       = rsp_data_ff[4:3];
   assign chk_undef_sev = (rsp_stat != lahd_pkg::STAT_UNDEF) ||
                          (rsp_sev == lahd_pkg::SEV_INVALID);
   assign chk_none_sev  = (rsp_stat == lahd_pkg::STAT_NONE) ==
                          (rsp_sev == lahd_pkg::SEV_NONE);
   assign s1_stall      = s1_valid_ff && !out_free;

`include "level_alarm_with_hysteresis_deadband_assert.svh"

   `LAHD_ASSERT_IMP(a_undef_is_invalid, clock, reset, rsp_valid_ff, chk_undef_sev)
   `LAHD_ASSERT_IMP(a_none_iff_no_sev, clock, reset, rsp_valid_ff, chk_none_sev)
   `LAHD_ASSERT_NXT(a_stage_holds, clock, reset, s1_stall, s1_valid_ff && $stable(s1_sample_ff))

endmodule
